@@ hw/rtl/dsmd_pkg.sv @@
// Shared types and constants for the dual sensor motion direction block.
// No dependencies; used by dsmd_side, dual_sensor_motion_direction, the checker and the testbench.
`default_nettype none

package dsmd_pkg;

	localparam int SAMPLE_W              = 12;
	localparam int HISTORY_DEPTH_DEFAULT = 4;
	localparam logic [SAMPLE_W-1:0] DEAD_BAND_RESET = 12'd2;

	typedef enum logic [1:0] {
		TREND_NEUTRAL = 2'd0,
		TREND_UP      = 2'd1,
		TREND_DOWN    = 2'd2
	} trend_t;

	typedef enum logic [1:0] {
		DIR_NONE  = 2'd0,
		DIR_RIGHT = 2'd1,
		DIR_LEFT  = 2'd2
	} dir_t;

	// Status of one side after the current item has been folded in
	typedef struct packed {
		logic   full;
		trend_t trend;
	} side_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/dsmd_side.sv @@
// One detector side: previous sample, sample history, dead band test and trend vote.
// Depends on dsmd_pkg.
`default_nettype none

module dsmd_side #(
	parameter int HISTORY_DEPTH = dsmd_pkg::HISTORY_DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          update,
	input  wire logic [dsmd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic [dsmd_pkg::SAMPLE_W-1:0] dead_band,
	output dsmd_pkg::side_stat_t               stat
);

	localparam int SW = dsmd_pkg::SAMPLE_W;
	localparam int CW = $clog2(HISTORY_DEPTH);

	logic [SW-1:0] prev_q;
	logic [SW-1:0] hist_q   [HISTORY_DEPTH];
	logic [SW-1:0] hist_nxt [HISTORY_DEPTH];
	logic [SW-1:0] mag;
	logic          moved;
	logic          full_nxt;
	logic [CW-1:0] up_cnt;
	logic [CW-1:0] down_cnt;
	logic          walk;

	// Magnitude of the change against the previous sample
	always_comb begin
		if (sample >= prev_q) begin
			mag = sample - prev_q;
		end else begin
			mag = prev_q - sample;
		end
		moved = (mag != '0) && (mag >= dead_band);
	end

	// Shift in a real change, clear the history otherwise
	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (!moved) begin
				hist_nxt[i] = '0;
			end else if (i == 0) begin
				hist_nxt[i] = sample;
			end else begin
				hist_nxt[i] = hist_q[i-1];
			end
		end
	end

	// Full when no entry is empty
	always_comb begin
		full_nxt = 1'b1;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (hist_nxt[i] == '0) begin
				full_nxt = 1'b0;
			end
		end
	end

	// Vote over neighbouring entries, stop at the first empty older entry
	always_comb begin
		up_cnt   = '0;
		down_cnt = '0;
		walk     = 1'b1;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			walk = walk && (hist_nxt[i] != '0);
			if (walk && (hist_nxt[i] > hist_nxt[i-1])) begin
				down_cnt = down_cnt + CW'(1);
			end
			if (walk && (hist_nxt[i] < hist_nxt[i-1])) begin
				up_cnt = up_cnt + CW'(1);
			end
		end
	end

	always_comb begin
		stat.full = full_nxt;
		if (up_cnt > down_cnt) begin
			stat.trend = dsmd_pkg::TREND_UP;
		end else if (up_cnt == down_cnt) begin
			stat.trend = dsmd_pkg::TREND_NEUTRAL;
		end else begin
			stat.trend = dsmd_pkg::TREND_DOWN;
		end
	end

	// Advance the side state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else if (update) begin
			prev_q <= sample;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_nxt[i];
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dual_sensor_motion_direction.sv @@
// Top level of the dual sensor motion direction block.
// Depends on dsmd_pkg and dsmd_side.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one left and one right 12-bit
//   detector sample per item. Output channel (out_valid/out_ready) returns one
//   direction per item: 0 not moving, 1 moving right, 2 moving left.
//   Configuration channel (cfg_valid/cfg_ready, data on dead_band) sets the
//   dead band; write it only while no item is in flight. cfg_ready is always high.
// Timing:
//   An item is registered at acceptance in the input register; on advance it
//   is folded into both side histories and its direction is loaded into the
//   result register. One item per cycle is sustained while out_ready stays
//   high: the history update and trend vote of each side are combinational.
// Reset:
//   arst_n clears both previous samples and histories, empties the pipeline
//   and loads the dead band with 2.
// Stall:
//   While out_ready is low the result holds; one further item waits in the
//   input register, then in_ready drops until the result is taken.
`default_nettype none

module dual_sensor_motion_direction #(
	parameter int HISTORY_DEPTH = dsmd_pkg::HISTORY_DEPTH_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [dsmd_pkg::SAMPLE_W-1:0] left_sample,
	input  wire logic [dsmd_pkg::SAMPLE_W-1:0] right_sample,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         direction,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [dsmd_pkg::SAMPLE_W-1:0] dead_band
);

	localparam int SW = dsmd_pkg::SAMPLE_W;

	logic                 valid_s1;
	logic [SW-1:0]        left_s1;
	logic [SW-1:0]        right_s1;
	logic                 advance;
	logic [SW-1:0]        dead_band_q;
	logic                 out_valid_q;
	dsmd_pkg::dir_t       direction_q;
	dsmd_pkg::dir_t       dir_nxt;
	dsmd_pkg::side_stat_t left_stat;
	dsmd_pkg::side_stat_t right_stat;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign direction = 2'(direction_q);

	// Hold the dead band register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= dsmd_pkg::DEAD_BAND_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dead_band_q <= dead_band;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			left_s1  <= left_sample;
			right_s1 <= right_sample;
		end
	end

	dsmd_side #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (advance),
		.sample   (left_s1),
		.dead_band(dead_band_q),
		.stat     (left_stat)
	);

	dsmd_side #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (advance),
		.sample   (right_s1),
		.dead_band(dead_band_q),
		.stat     (right_stat)
	);

	// Combine the two trends into a direction
	always_comb begin
		dir_nxt = dsmd_pkg::DIR_NONE;
		if (left_stat.full || right_stat.full) begin
			priority if (right_stat.trend == dsmd_pkg::TREND_UP ||
			             left_stat.trend == dsmd_pkg::TREND_DOWN) begin
				dir_nxt = dsmd_pkg::DIR_RIGHT;
			end else if (right_stat.trend == dsmd_pkg::TREND_DOWN ||
			             left_stat.trend == dsmd_pkg::TREND_UP) begin
				dir_nxt = dsmd_pkg::DIR_LEFT;
			end else begin
				dir_nxt = dsmd_pkg::DIR_NONE;
			end
		end
	end

	// Result register: load on advance, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			direction_q <= dir_nxt;
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/dsmd_motion_checker.sv @@
// Checker for the dual sensor motion direction block: tracks both sample
// histories, forecasts each direction and compares it with the output channel.
// Depends on dsmd_pkg.
`timescale 1ns / 1ps

module dsmd_motion_checker
	import dsmd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [SAMPLE_W-1:0] left_sample,
	input  logic [SAMPLE_W-1:0] right_sample,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          direction,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [SAMPLE_W-1:0] dead_band,
	output int                  pending,
	output int                  fail_count
);

	localparam int HD = HISTORY_DEPTH_DEFAULT;

	typedef logic [HD-1:0][SAMPLE_W-1:0] hist_t;

	logic [SAMPLE_W-1:0] band_q;
	logic [SAMPLE_W-1:0] last_left;
	logic [SAMPLE_W-1:0] last_right;
	hist_t               left_hist;
	hist_t               right_hist;
	dir_t                dir_forecast[$];
	int                  fails;

	// A zero difference never counts, whatever the band
	function automatic logic real_move(input logic [SAMPLE_W-1:0] now,
		input logic [SAMPLE_W-1:0] prior, input logic [SAMPLE_W-1:0] band);
		logic [SAMPLE_W-1:0] mag;
		mag = (now >= prior) ? now - prior : prior - now;
		return (mag != '0) && (mag >= band);
	endfunction

	// Shift a moved sample in as the newest entry, or clear the history
	function automatic hist_t fold_sample(input hist_t h, input logic [SAMPLE_W-1:0] now,
		input logic moved);
		if (!moved)
			return '0;
		return {h[HD-2:0], now};
	endfunction

	function automatic logic hist_full(input hist_t h);
		logic full;
		full = 1'b1;
		for (int i = 0; i < HD; i++)
			if (h[i] == '0)
				full = 1'b0;
		return full;
	endfunction

	// Majority vote of neighbouring entries, stopping at the first empty one
	function automatic trend_t hist_trend(input hist_t h);
		int   ups;
		int   downs;
		logic stopped;
		ups     = 0;
		downs   = 0;
		stopped = 1'b0;
		for (int i = 1; i < HD; i++) begin
			if (h[i] == '0)
				stopped = 1'b1;
			if (!stopped) begin
				if (h[i] > h[i-1])
					downs++;
				else if (h[i] < h[i-1])
					ups++;
			end
		end
		if (ups > downs)
			return TREND_UP;
		if (ups == downs)
			return TREND_NEUTRAL;
		return TREND_DOWN;
	endfunction

	// Advance the side state by one item and forecast its direction
	function automatic dir_t forecast_direction(input logic [SAMPLE_W-1:0] l,
		input logic [SAMPLE_W-1:0] r);
		logic   ml;
		logic   mr;
		trend_t tl;
		trend_t tr;
		dir_t   d;
		ml         = real_move(l, last_left, band_q);
		mr         = real_move(r, last_right, band_q);
		last_left  = l;
		last_right = r;
		left_hist  = fold_sample(left_hist, l, ml);
		right_hist = fold_sample(right_hist, r, mr);
		d = DIR_NONE;
		if (hist_full(right_hist) || hist_full(left_hist)) begin
			tr = hist_trend(right_hist);
			tl = hist_trend(left_hist);
			if (tr == TREND_UP || tl == TREND_DOWN)
				d = DIR_RIGHT;
			else if (tr == TREND_DOWN || tl == TREND_UP)
				d = DIR_LEFT;
		end
		return d;
	endfunction

	// Watch all three channels; compare results before queueing new items
	always @(posedge clk or negedge arst_n) begin
		dir_t want;
		if (!arst_n) begin
			band_q     = DEAD_BAND_RESET;
			last_left  = '0;
			last_right = '0;
			left_hist  = '0;
			right_hist = '0;
			dir_forecast.delete();
			fails      = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (dir_forecast.size() == 0) begin
					$display("%0t: unexpected direction item, expected none, got %0d",
						$time, direction);
					fails++;
				end else begin
					want = dir_forecast.pop_front();
					if (direction !== want) begin
						$display("%0t: direction mismatch, expected %0d, got %0d",
							$time, want, direction);
						fails++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				band_q = dead_band;
			if (in_valid && in_ready)
				dir_forecast.push_back(forecast_direction(left_sample, right_sample));
			pending    <= dir_forecast.size();
			fail_count <= fails;
		end
	end

endmodule

@@ tb/sv/tb_dual_sensor_motion_direction.sv @@
// Testbench top for the dual sensor motion direction block: drives directed
// and random sample sequences under several dead bands. Depends on dsmd_pkg,
// dual_sensor_motion_direction and dsmd_motion_checker.
`timescale 1ns / 1ps

module tb_dual_sensor_motion_direction;
	import dsmd_pkg::*;

	localparam int MAX_S = (1 << SAMPLE_W) - 1;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [SAMPLE_W-1:0] left_sample;
	logic [SAMPLE_W-1:0] right_sample;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          direction;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [SAMPLE_W-1:0] dead_band;
	int                  pending;
	int                  fail_count;

	int gap_rate;
	int stall_rate;
	int stall_left;
	int items_sent;

	dual_sensor_motion_direction i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.direction    (direction),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.dead_band    (dead_band)
	);

	dsmd_motion_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.direction    (direction),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.dead_band    (dead_band),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes hang
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Drop out_ready in short random bursts
	always @(posedge clk) begin
		if (stall_rate == 0) begin
			out_ready  <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, stall_rate - 1) == 0) begin
			out_ready  <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one item, with an optional idle burst first, and hold until taken
	task automatic send_item(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
		if (gap_rate != 0 && $urandom_range(0, gap_rate - 1) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Drain all results, then load a new dead band
	task automatic write_band(input logic [SAMPLE_W-1:0] band);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		dead_band <= band;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
		if (v < 0)
			return '0;
		if (v > MAX_S)
			return SAMPLE_W'(MAX_S);
		return v[SAMPLE_W-1:0];
	endfunction

	// Step per item: mostly above the band, sometimes just under it, equal to it or flat
	function automatic int pick_step(input int band);
		int mag;
		case ($urandom_range(0, 9))
			0: mag = 0;
			1: mag = (band > 0) ? band - 1 : 0;
			2: mag = band;
			default: mag = band + $urandom_range(1, 80);
		endcase
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	// Mix ramps with random content, full-swing toggles and pure noise
	task automatic run_phase(input int count, input int band);
		int start;
		int len;
		int kind;
		int base_l;
		int base_r;
		int step_l;
		int step_r;
		logic [SAMPLE_W-1:0] vl;
		logic [SAMPLE_W-1:0] vr;
		start = items_sent;
		while (items_sent - start < count) begin
			kind = $urandom_range(0, 9);
			len  = $urandom_range(3, 8);
			if (kind < 7) begin
				base_l = $urandom_range(0, MAX_S);
				base_r = $urandom_range(0, MAX_S);
				step_l = pick_step(band);
				step_r = pick_step(band);
				for (int k = 0; k < len; k++) begin
					vl = clamp_sample(base_l + step_l * k);
					vr = clamp_sample(base_r + step_r * k);
					if ($urandom_range(0, 15) == 0)
						vl = '0;
					if ($urandom_range(0, 15) == 0)
						vr = '0;
					send_item(vl, vr);
				end
			end else if (kind == 7) begin
				for (int k = 0; k < len; k++)
					send_item((k % 2) ? SAMPLE_W'(MAX_S) : '0,
						(k % 2) ? '0 : SAMPLE_W'(MAX_S));
			end else begin
				for (int k = 0; k < len / 2; k++)
					send_item(SAMPLE_W'($urandom_range(0, MAX_S)),
						SAMPLE_W'($urandom_range(0, MAX_S)));
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		out_ready    = 1'b1;
		cfg_valid    = 1'b0;
		dead_band    = '0;
		gap_rate     = 0;
		stall_rate   = 0;
		stall_left   = 0;
		items_sent   = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset dead band
		gap_rate   = 4;
		stall_rate = 4;
		send_item(0, 0);             // no change from reset
		send_item(SAMPLE_W'(MAX_S), SAMPLE_W'(MAX_S));     // full-scale jump
		send_item(0, 0);             // real change to a zero sample
		send_item(1, 1);             // change under the band clears
		send_item(1, 100);           // right ramps up
		send_item(1, 200);
		send_item(1, 300);
		send_item(1, 400);
		send_item(1, 500);
		send_item(1000, 500);        // left ramps up
		send_item(1500, 500);
		send_item(2000, 500);
		send_item(2500, 500);
		send_item(3000, 500);
		send_item(2000, 500);        // left ramps down
		send_item(1000, 500);
		send_item(500, 500);
		send_item(100, 500);
		send_item(100, 400);         // right ramps down
		send_item(100, 300);
		send_item(100, 200);
		send_item(100, 100);
		send_item(SAMPLE_W'(MAX_S), 0);
		send_item(SAMPLE_W'(MAX_S - 2), 0);     // change equal to the band counts

		// Zero band: a zero difference still does not count
		write_band(0);
		send_item(SAMPLE_W'(MAX_S - 2), 0);
		send_item(SAMPLE_W'(MAX_S - 3), 1);

		// Random phases over several bands
		write_band(DEAD_BAND_RESET);
		run_phase(300, DEAD_BAND_RESET);
		gap_rate   = 2;
		stall_rate = 8;
		write_band(0);
		run_phase(250, 0);
		gap_rate   = 6;
		stall_rate = 3;
		write_band(SAMPLE_W'(MAX_S));
		run_phase(100, MAX_S);
		write_band(1);
		run_phase(250, 1);
		begin
			logic [SAMPLE_W-1:0] band_r;
			band_r = SAMPLE_W'($urandom_range(0, 400));
			write_band(band_r);
			run_phase(250, band_r);
		end

		// Final stretch with no idling on either side
		gap_rate   = 0;
		stall_rate = 0;
		write_band(20);
		run_phase(300, 20);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
